FILE: design/mbt_pkg.sv
// mbt_pkg: shared types and constants of the Mandelbrot escape-time tile.
// Fixed-point word type, configuration bundle, core status and register indexes.
// No dependencies.
package mbt_pkg;

    localparam int FIX_W     = 64;
    localparam int PIX_W     = 9;
    localparam int ZOOM_W    = 6;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [FIX_W-1:0] t_fix;

    localparam t_fix FIX_MAX = t_fix'({1'b0, {(FIX_W-1){1'b1}}});
    localparam t_fix FIX_MIN = t_fix'({1'b1, {(FIX_W-1){1'b0}}});

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_REAL = 2'd0,
        CFG_CENTER_IMAG = 2'd1,
        CFG_ZOOM_LEVEL  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_fix              center_real;
        t_fix              center_imag;
        logic [ZOOM_W-1:0] zoom_level;
    } t_cfg;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] count;
    } t_core_stat;

endpackage

FILE: design/mbt_channels.sv
// mbt_channels: valid/ready channel interfaces of the escape-time tile.
// Pixel input, escape count result and register write channels.
// Depends on mbt_pkg.
interface mbt_pix_if;
    import mbt_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_row;
    logic [PIX_W-1:0] pixel_col;
    modport source(output valid, output pixel_row, output pixel_col, input ready);
    modport sink(input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface mbt_res_if;
    import mbt_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] escape_count;
    modport source(output valid, output escape_count, input ready);
    modport sink(input valid, input escape_count, output ready);
endinterface

interface mbt_cfg_if;
    import mbt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [FIX_W-1:0]     data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

FILE: design/mandelbrot_escape_tile.sv
// mandelbrot_escape_tile: top level of the Mandelbrot escape-time tile engine.
// Holds the configuration registers and the result register around mbt_core.
// Depends on mbt_pkg, mbt_channels, mbt_core.
//
//  channel  | dir | payload                          | transfer when
//  ---------+-----+----------------------------------+-------------------------
//  i_pix    | in  | pixel_row[8:0], pixel_col[8:0]   | valid & ready, core idle
//  o_res    | out | escape_count[7:0]                | valid & ready
//  i_cfg    | in  | index[1:0], data[63:0]           | valid & ready, always ready
//
// Each pixel runs one escape step after another until the point escapes or
// STEP_LIMIT steps are done. Each step runs three fixed-point products through
// the single 32x32 multiplier, 4 partial products per product, plus the
// saturating adds and the escape test.
// Reset clears the configuration to zero and empties the result register.
// A waiting result stalls only the next pixel's finish, not its acceptance.
module mandelbrot_escape_tile #(
    parameter int TILE_WIDTH = 512,
    parameter int STEP_LIMIT = 256,
    parameter int FRAC_BITS  = 60
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbt_pix_if.sink   i_pix,
    mbt_cfg_if.sink   i_cfg,
    mbt_res_if.source o_res
);
    import mbt_pkg::*;

    t_cfg             r_cfg;
    logic             r_res_vld;
    logic [CNT_W-1:0] r_res_cnt;

    t_core_stat       w_stat;
    logic             w_start;
    logic             w_res_free;

    // config port never stalls; write only while the engine is idle, since the
    // core reads the registers while a pixel is in progress
    assign i_cfg.ready = 1'b1;

    // take a new pixel whenever the core is idle, even with a result pending
    assign i_pix.ready = !w_stat.busy;
    assign w_start     = i_pix.valid && !w_stat.busy;

    // result register frees up when empty or when its transfer completes
    assign w_res_free = !r_res_vld || o_res.ready;

    mbt_core #(
        .TILE_WIDTH (TILE_WIDTH),
        .STEP_LIMIT (STEP_LIMIT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_row      (i_pix.pixel_row),
        .i_col      (i_pix.pixel_col),
        .i_cfg      (r_cfg),
        .i_res_free (w_res_free),
        .o_stat     (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CENTER_REAL: r_cfg.center_real <= t_fix'(i_cfg.data);
                CFG_CENTER_IMAG: r_cfg.center_imag <= t_fix'(i_cfg.data);
                CFG_ZOOM_LEVEL:  r_cfg.zoom_level  <= i_cfg.data[ZOOM_W-1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (w_stat.done) begin
            r_res_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_res_vld <= 1'b0;
        end
        if (w_stat.done) begin
            r_res_cnt <= w_stat.count;
        end
    end

    assign o_res.valid        = r_res_vld;
    assign o_res.escape_count = r_res_cnt;

endmodule

FILE: design/mbt_mul.sv
// mbt_mul: shared fixed-point multiplier built on one 32x32 unsigned multiplier.
// Four partial products per operand pair, then truncate and saturate.
// Depends on mbt_pkg.
module mbt_mul #(
    parameter int FRAC_BITS = 60
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  mbt_pkg::t_fix i_a,
    input  mbt_pkg::t_fix i_b,
    output logic         o_done,
    output mbt_pkg::t_fix o_p
);
    import mbt_pkg::*;

    localparam int HW    = FIX_W / 2;
    localparam int ACC_W = 2 * FIX_W;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state             r_state, n_state;
    logic [FIX_W-1:0]   r_ua, n_ua, r_ub, n_ub;
    logic               r_neg, n_neg;
    logic [2:0]         r_cnt, n_cnt;
    logic [FIX_W-1:0]   r_prod, n_prod;
    logic [1:0]         r_pidx, n_pidx;
    logic               r_pvld, n_pvld;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic               r_done, n_done;
    t_fix               r_p, n_p;

    logic [HW-1:0]      a_sel, b_sel;
    logic [ACC_W-1:0]   addend, shifted;
    logic [FIX_W-1:0]   mag;

    function automatic logic [FIX_W-1:0] magnitude(t_fix a);
        return a[FIX_W-1] ? (~unsigned'(a) + 1'b1) : unsigned'(a);
    endfunction

    always_comb begin
        a_sel = r_cnt[1] ? r_ua[FIX_W-1:HW] : r_ua[HW-1:0];
        b_sel = r_cnt[0] ? r_ub[FIX_W-1:HW] : r_ub[HW-1:0];
        case (r_pidx)
            2'd0:    addend = ACC_W'(r_prod);
            2'd3:    addend = ACC_W'(r_prod) << FIX_W;
            default: addend = ACC_W'(r_prod) << HW;
        endcase
        shifted = r_acc >> FRAC_BITS;
        mag     = shifted[FIX_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_ua    = r_ua;
        n_ub    = r_ub;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_pidx  = r_pidx;
        n_pvld  = 1'b0;
        n_acc   = r_acc;
        n_done  = 1'b0;
        n_p     = r_p;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ua    = magnitude(i_a);
                    n_ub    = magnitude(i_b);
                    n_neg   = i_a[FIX_W-1] ^ i_b[FIX_W-1];
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // issue one partial product per cycle, fold the previous one in
                if (!r_cnt[2]) begin
                    n_prod = FIX_W'(a_sel) * FIX_W'(b_sel);
                    n_pidx = r_cnt[1:0];
                    n_pvld = 1'b1;
                    n_cnt  = r_cnt + 3'd1;
                end
                if (r_pvld) begin
                    n_acc = r_acc + addend;
                end
                if (r_cnt[2]) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (shifted[ACC_W-1:FIX_W] != '0) begin
                    n_p = r_neg ? FIX_MIN : FIX_MAX;
                end else if (r_neg) begin
                    n_p = mag[FIX_W-1] ? FIX_MIN : -t_fix'(mag);
                end else begin
                    n_p = mag[FIX_W-1] ? FIX_MAX : t_fix'(mag);
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pvld  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pvld  <= n_pvld;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_ua   <= n_ua;
        r_ub   <= n_ub;
        r_neg  <= n_neg;
        r_prod <= n_prod;
        r_pidx <= n_pidx;
        r_acc  <= n_acc;
        r_p    <= n_p;
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

FILE: design/mbt_core.sv
// mbt_core: per-pixel sequencer; pixel coordinate, saturating adds, escape test.
// Drives the shared multiplier mbt_mul for every product.
// Depends on mbt_pkg and mbt_mul.
module mbt_core #(
    parameter int TILE_WIDTH = 512,
    parameter int STEP_LIMIT = 256,
    parameter int FRAC_BITS  = 60
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mbt_pkg::PIX_W-1:0]  i_row,
    input  logic [mbt_pkg::PIX_W-1:0]  i_col,
    input  mbt_pkg::t_cfg              i_cfg,
    input  logic                       i_res_free,
    output mbt_pkg::t_core_stat        o_stat
);
    import mbt_pkg::*;

    localparam int TW_BITS = $clog2(TILE_WIDTH);
    localparam int MW      = ((TW_BITS > PIX_W) ? TW_BITS : PIX_W) + 2;
    localparam int WW      = FIX_W + MW;
    localparam int SW      = $clog2(STEP_LIMIT);
    localparam t_fix LIMIT = t_fix'(64'sd4 <<< FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_OFS, S_CEN, S_MXY, S_SUM1, S_SUM2, S_MXX, S_MYY, S_CHK, S_OUT
    } t_state;

    t_state             r_state, n_state;
    logic [PIX_W-1:0]   r_row, n_row, r_col, n_col;
    t_fix               r_ofs_re, n_ofs_re, r_ofs_im, n_ofs_im;
    t_fix               r_cre, n_cre, r_cim, n_cim;
    t_fix               r_x, n_x, r_y, n_y;
    t_fix               r_xx, n_xx, r_yy, n_yy, r_xy, n_xy;
    t_fix               r_t1, n_t1, r_t2, n_t2;
    logic [SW-1:0]      r_step, n_step;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_done, n_done;
    logic               r_mstart, n_mstart;

    logic [ZOOM_W-1:0]  k;
    t_fix               mul_a, mul_b, mul_p;
    logic               mul_done;

    function automatic t_fix sat_sum(logic signed [FIX_W:0] s);
        if (s[FIX_W] != s[FIX_W-1]) begin
            return s[FIX_W] ? FIX_MIN : FIX_MAX;
        end
        return s[FIX_W-1:0];
    endfunction

    function automatic t_fix sat_add(t_fix a, t_fix b);
        return sat_sum((FIX_W+1)'(a) + (FIX_W+1)'(b));
    endfunction

    function automatic t_fix sat_sub(t_fix a, t_fix b);
        return sat_sum((FIX_W+1)'(a) - (FIX_W+1)'(b));
    endfunction

    // (2*index - (W-1)) * 2^kk / 2, saturated
    function automatic t_fix pix_ofs(logic [PIX_W-1:0] idx, logic [ZOOM_W-1:0] kk);
        logic signed [MW-1:0] m;
        logic signed [WW-1:0] w;
        m = $signed(MW'({idx, 1'b0})) - $signed(MW'(TILE_WIDTH - 1));
        w = WW'(m) <<< (kk - ZOOM_W'(1));
        if (kk == '0) begin
            return FIX_W'(m >>> 1);
        end
        if ((&w[WW-1:FIX_W-1]) || !(|w[WW-1:FIX_W-1])) begin
            return w[FIX_W-1:0];
        end
        return w[WW-1] ? FIX_MIN : FIX_MAX;
    endfunction

    assign k = (i_cfg.zoom_level <= ZOOM_W'(FRAC_BITS))
             ? ZOOM_W'(FRAC_BITS) - i_cfg.zoom_level : '0;

    // operand select: x*y, x*x, y*y
    assign mul_a = (r_state == S_MYY) ? r_y : r_x;
    assign mul_b = (r_state == S_MXX) ? r_x : r_y;

    mbt_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_ofs_re = r_ofs_re;
        n_ofs_im = r_ofs_im;
        n_cre    = r_cre;
        n_cim    = r_cim;
        n_x      = r_x;
        n_y      = r_y;
        n_xx     = r_xx;
        n_yy     = r_yy;
        n_xy     = r_xy;
        n_t1     = r_t1;
        n_t2     = r_t2;
        n_step   = r_step;
        n_count  = r_count;
        n_done   = 1'b0;
        n_mstart = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_row   = i_row;
                    n_col   = i_col;
                    n_x     = '0;
                    n_y     = '0;
                    n_xx    = '0;
                    n_yy    = '0;
                    n_step  = '0;
                    n_state = S_OFS;
                end
            end
            S_OFS: begin
                n_ofs_re = pix_ofs(r_col, k);
                n_ofs_im = pix_ofs(r_row, k);
                n_state  = S_CEN;
            end
            S_CEN: begin
                n_cre    = sat_add(i_cfg.center_real, r_ofs_re);
                n_cim    = sat_add(i_cfg.center_imag, r_ofs_im);
                n_mstart = 1'b1;
                n_state  = S_MXY;
            end
            S_MXY: begin
                if (mul_done) begin
                    n_xy    = mul_p;
                    n_state = S_SUM1;
                end
            end
            S_SUM1: begin
                n_t1    = sat_sub(r_xx, r_yy);
                n_t2    = sat_add(r_xy, r_xy);
                n_state = S_SUM2;
            end
            S_SUM2: begin
                n_x      = sat_add(r_t1, r_cre);
                n_y      = sat_add(r_t2, r_cim);
                n_mstart = 1'b1;
                n_state  = S_MXX;
            end
            S_MXX: begin
                if (mul_done) begin
                    n_xx     = mul_p;
                    n_mstart = 1'b1;
                    n_state  = S_MYY;
                end
            end
            S_MYY: begin
                if (mul_done) begin
                    n_yy    = mul_p;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // the squares just formed serve as the next step's xx and yy
                if (sat_add(r_xx, r_yy) > LIMIT) begin
                    n_count = (32'(r_step) > 32'd255) ? '1 : CNT_W'(r_step);
                    n_state = S_OUT;
                end else if (r_step == SW'(STEP_LIMIT - 1)) begin
                    n_count = '0;
                    n_state = S_OUT;
                end else begin
                    n_step   = r_step + SW'(1);
                    n_mstart = 1'b1;
                    n_state  = S_MXY;
                end
            end
            S_OUT: begin
                if (i_res_free) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_mstart <= n_mstart;
        end
        r_row    <= n_row;
        r_col    <= n_col;
        r_ofs_re <= n_ofs_re;
        r_ofs_im <= n_ofs_im;
        r_cre    <= n_cre;
        r_cim    <= n_cim;
        r_x      <= n_x;
        r_y      <= n_y;
        r_xx     <= n_xx;
        r_yy     <= n_yy;
        r_xy     <= n_xy;
        r_t1     <= n_t1;
        r_t2     <= n_t2;
        r_step   <= n_step;
        r_count  <= n_count;
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.done  = r_done;
    assign o_stat.count = r_count;

endmodule

FILE: tb/escape_count_checker.sv
`timescale 1ns / 1ps
// escape_count_checker: watches the pixel, register and result channels of the
// escape-time tile, predicts each escape count and compares it. Uses mbt_pkg.
module escape_count_checker #(
    parameter int TILE_WIDTH = 512,
    parameter int STEP_LIMIT = 256,
    parameter int FRAC_BITS  = 60
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mbt_pix_if   i_pix,
    mbt_cfg_if   i_cfg,
    mbt_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_nonzero
);
    import mbt_pkg::*;

    localparam t_fix ESCAPE_LIMIT = t_fix'(64'sd4 <<< FRAC_BITS);

    typedef struct {
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] col;
        logic [CNT_W-1:0] count;
    } t_count_due;

    t_cfg       cfg_shadow;
    t_count_due counts_due[$];
    int         fail_total;
    int         checked_total;
    int         nonzero_total;

    function automatic t_fix clamp_fix(input logic signed [127:0] v);
        if (v > FIX_MAX) return FIX_MAX;
        if (v < FIX_MIN) return FIX_MIN;
        return t_fix'(v[FIX_W-1:0]);
    endfunction

    function automatic t_fix fix_add(input t_fix a, input t_fix b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return clamp_fix(wa + wb);
    endfunction

    function automatic t_fix fix_sub(input t_fix a, input t_fix b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return clamp_fix(wa - wb);
    endfunction

    // Magnitude product, truncated toward zero, then saturated.
    function automatic t_fix fix_mul(input t_fix a, input t_fix b);
        logic [FIX_W-1:0] mag_a;
        logic [FIX_W-1:0] mag_b;
        logic [127:0]     prod;
        logic             neg;
        neg   = a[FIX_W-1] ^ b[FIX_W-1];
        mag_a = a[FIX_W-1] ? FIX_W'(-a) : FIX_W'(a);
        mag_b = b[FIX_W-1] ? FIX_W'(-b) : FIX_W'(b);
        prod  = {64'd0, mag_a} * {64'd0, mag_b};
        prod  = prod >> FRAC_BITS;
        if (prod[127:63] != '0) return neg ? FIX_MIN : FIX_MAX;
        return neg ? -t_fix'(prod[FIX_W-1:0]) : t_fix'(prod[FIX_W-1:0]);
    endfunction

    // Offset of a pixel from the tile centre; k is log2 of the spacing in LSBs.
    function automatic t_fix grid_offset(input logic [PIX_W-1:0] index, input int k);
        logic signed [127:0] m;
        m = 128'(index);
        m = 2 * m - (TILE_WIDTH - 1);
        if (k == 0) return clamp_fix(m >>> 1);
        return clamp_fix(m <<< (k - 1));
    endfunction

    function automatic logic [CNT_W-1:0] predict_count(input logic [PIX_W-1:0] row,
                                                       input logic [PIX_W-1:0] col,
                                                       input t_cfg c);
        int               k;
        int               step;
        t_fix             c_re;
        t_fix             c_im;
        t_fix             x;
        t_fix             y;
        t_fix             xx;
        t_fix             yy;
        t_fix             xy;
        logic             escaped;
        logic [CNT_W-1:0] count;
        k       = (int'(c.zoom_level) <= FRAC_BITS) ? FRAC_BITS - int'(c.zoom_level) : 0;
        c_re    = fix_add(c.center_real, grid_offset(col, k));
        c_im    = fix_add(c.center_imag, grid_offset(row, k));
        x       = '0;
        y       = '0;
        step    = 0;
        escaped = 1'b0;
        count   = '0;
        while (!escaped && step < STEP_LIMIT) begin
            xx = fix_mul(x, x);
            yy = fix_mul(y, y);
            xy = fix_mul(x, y);
            x  = fix_add(fix_sub(xx, yy), c_re);
            y  = fix_add(fix_add(xy, xy), c_im);
            if (fix_add(fix_mul(x, x), fix_mul(y, y)) > ESCAPE_LIMIT) begin
                escaped = 1'b1;
                count   = (step > 255) ? CNT_W'(255) : CNT_W'(step);
            end
            step++;
        end
        return count;
    endfunction

    always @(posedge i_clk) begin
        t_count_due due;
        if (!i_rst_n) begin
            cfg_shadow    = '0;
            counts_due.delete();
            fail_total    = 0;
            checked_total = 0;
            nonzero_total = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_CENTER_REAL: cfg_shadow.center_real = t_fix'(i_cfg.data);
                    CFG_CENTER_IMAG: cfg_shadow.center_imag = t_fix'(i_cfg.data);
                    CFG_ZOOM_LEVEL:  cfg_shadow.zoom_level  = i_cfg.data[ZOOM_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (counts_due.size() == 0) begin
                    fail_total++;
                    $display("%0t: escape count %0d transferred with no pixel outstanding",
                             $time, i_res.escape_count);
                end else begin
                    due = counts_due.pop_front();
                    checked_total++;
                    if (due.count != 0) nonzero_total++;
                    if (i_res.escape_count !== due.count) begin
                        fail_total++;
                        $display("%0t: escape count, row %0d col %0d: expected %0d, actual %0d",
                                 $time, due.row, due.col, due.count, i_res.escape_count);
                    end
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                due.row   = i_pix.pixel_row;
                due.col   = i_pix.pixel_col;
                due.count = predict_count(i_pix.pixel_row, i_pix.pixel_col, cfg_shadow);
                counts_due.push_back(due);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= counts_due.size();
        o_checked    <= checked_total;
        o_nonzero    <= nonzero_total;
    end

endmodule

FILE: tb/mandelbrot_escape_tile_tb.sv
`timescale 1ns / 1ps
// mandelbrot_escape_tile_tb: stimulus and verdict for the escape-time tile.
// Uses mbt_pkg, mbt_channels, mandelbrot_escape_tile and escape_count_checker.
module mandelbrot_escape_tile_tb;
    import mbt_pkg::*;

    localparam int TILE_WIDTH = 512;
    localparam int STEP_LIMIT = 256;
    localparam int FRAC_BITS  = 60;

    // Wait about as long as the slowest pixel takes after the last count, to
    // catch any stray transfer.
    localparam int DRAIN_CYCLES = 7000;
    // ~1050 pixels at worst case plus the longest gaps and stalls, taken ~4x.
    localparam int CYCLE_LIMIT  = 40_000_000;
    localparam int RANDOM_ITEMS = 1030;

    // Register index past the end of the register list; writes are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    localparam t_fix FIX_ONE = t_fix'(64'sd1 <<< FRAC_BITS);

    logic i_clk;
    logic i_rst_n;

    mbt_pix_if pix_ch ();
    mbt_cfg_if cfg_ch ();
    mbt_res_if res_ch ();

    int fail_count;
    int pending;
    int checked;
    int nonzero;

    int cycle_count;
    int pixels_sent;
    int settings_used;

    // Result-side stall control: the enable is set per phase, the countdown is owned by the ready driver below.
    logic res_stalls_on;
    int   stall_left;

    mandelbrot_escape_tile #(
        .TILE_WIDTH(TILE_WIDTH),
        .STEP_LIMIT(STEP_LIMIT),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch),
        .i_cfg  (cfg_ch),
        .o_res  (res_ch)
    );

    escape_count_checker #(
        .TILE_WIDTH(TILE_WIDTH),
        .STEP_LIMIT(STEP_LIMIT),
        .FRAC_BITS (FRAC_BITS)
    ) u_count_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .i_cfg       (cfg_ch),
        .i_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_nonzero   (nonzero)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Random idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Drop ready for random stretches while stalls are enabled for the phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else if (res_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = idle_len();
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached with %0d counts outstanding", $time, pending);
        $display("FAILED: results differ");
        $finish;
    end

    // Present one pixel and hold it until the transfer; then idle for the given gap.
    // Valid stays high across a zero gap so back-to-back pixels need no toggle.
    task automatic send_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col,
                              input int gap);
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel_row <= row;
        pix_ch.pixel_col <= col;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        pixels_sent++;
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One register transfer; drop valid for a cycle so writes never merge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIX_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load a full setting; the zoom word carries random junk above its six bits.
    task automatic apply_setting(input t_fix re, input t_fix im, input logic [ZOOM_W-1:0] zoom);
        logic [FIX_W-1:0] zoom_word;
        zoom_word = {$urandom, $urandom};
        zoom_word[ZOOM_W-1:0] = zoom;
        write_reg(CFG_CENTER_REAL, re);
        write_reg(CFG_CENTER_IMAG, im);
        write_reg(CFG_ZOOM_LEVEL, zoom_word);
        settings_used++;
    endtask

    // Drop the pixel valid and hold until every predicted count has arrived.
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int               items_left;
        int               phase_items;
        int               mode;
        logic             gaps_on;
        logic [63:0]      raw;
        t_fix             re;
        t_fix             im;
        logic [ZOOM_W-1:0] zoom;

        pixels_sent   = 0;
        settings_used = 0;
        res_stalls_on <= 1'b0;
        i_rst_n          <= 1'b0;
        pix_ch.valid     <= 1'b0;
        pix_ch.pixel_row <= '0;
        pix_ch.pixel_col <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: centre zero, spacing one whole unit. Tile corners escape at
        // step zero; pixel row 255, col 256 sits at +0.5 real, -0.5 imaginary.
        send_pixel(9'd0, 9'd0, 0);
        send_pixel(9'd511, 9'd511, 1);
        send_pixel(9'd0, 9'd511, 0);
        send_pixel(9'd511, 9'd0, 2);
        send_pixel(9'd255, 9'd256, 0);
        wait_idle();

        // Centre at the extremes: coordinates saturate at both rails.
        res_stalls_on <= 1'b1;
        apply_setting(FIX_MAX, FIX_MIN, 6'd0);
        send_pixel(9'd511, 9'd511, 0);
        send_pixel(9'd0, 9'd0, 0);
        send_pixel(9'd0, 9'd511, 3);
        wait_idle();

        // Zoom past the fraction width clamps the spacing to one LSB; the whole
        // tile sits inside the main cardioid and never escapes.
        apply_setting(-(FIX_ONE >>> 1), '0, 6'd63);
        send_pixel(9'd0, 9'd0, 0);
        send_pixel(9'd511, 9'd511, 0);
        wait_idle();

        // Spare index must be ignored; then exactly one-LSB spacing with the
        // half-pixel offset rounded down, just right of the cusp at 0.25.
        write_reg(CFG_IDX_SPARE, '1);
        apply_setting((FIX_ONE / 50) * 13, '0, 6'd60);
        send_pixel(9'd0, 9'd511, 0);
        send_pixel(9'd256, 9'd255, 0);
        wait_idle();
        apply_setting((FIX_ONE / 50) * 13, FIX_ONE / 1000, 6'd61);
        send_pixel(9'd511, 9'd0, 0);
        wait_idle();

        // Tile across the cardioid and bulb boundary: a spread of counts.
        apply_setting(-((FIX_ONE >>> 2) * 3), FIX_ONE / 10, 6'd7);
        send_pixel(9'd0, 9'd0, 0);
        send_pixel(9'd170, 9'd340, 1);
        send_pixel(9'd341, 9'd85, 0);
        send_pixel(9'd256, 9'd256, 0);
        send_pixel(9'd511, 9'h155, 0);
        wait_idle();

        // Random phases: a fresh setting each time, then random pixels.
        items_left = RANDOM_ITEMS;
        while (items_left > 0) begin
            mode = $urandom_range(0, 9);
            raw  = {$urandom, $urandom};
            re   = -(FIX_ONE <<< 1) + t_fix'(raw >> 2);
            raw  = {$urandom, $urandom};
            im   = t_fix'(raw) >>> 3;
            if (mode <= 5) begin
                // Whole-set views: tile spans 16 down to 1 unit.
                zoom        = ZOOM_W'($urandom_range(5, 9));
                phase_items = $urandom_range(60, 120);
            end else if (mode <= 7) begin
                zoom        = ZOOM_W'($urandom_range(10, 45));
                phase_items = $urandom_range(8, 20);
            end else if (mode == 8) begin
                // Anywhere in the number range, coarse spacing: saturation.
                zoom = ZOOM_W'($urandom_range(0, 4));
                case ($urandom_range(0, 3))
                    0: re = FIX_MAX;
                    1: re = FIX_MIN;
                    default: re = t_fix'({$urandom, $urandom});
                endcase
                case ($urandom_range(0, 3))
                    0: im = FIX_MIN;
                    1: im = FIX_MAX;
                    default: im = t_fix'({$urandom, $urandom});
                endcase
                phase_items = $urandom_range(20, 60);
            end else begin
                // Spacing of 32 LSBs down to one LSB.
                zoom        = ZOOM_W'($urandom_range(55, 63));
                phase_items = $urandom_range(6, 12);
            end
            if (phase_items > items_left) phase_items = items_left;

            if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
            apply_setting(re, im, zoom);
            res_stalls_on <= ($urandom_range(0, 3) != 0);
            gaps_on = ($urandom_range(0, 3) != 0);

            repeat (phase_items) begin
                send_pixel(PIX_W'($urandom_range(0, 511)), PIX_W'($urandom_range(0, 511)),
                           gaps_on ? idle_len() : 0);
                // Now and then hold off until the block has drained.
                if ($urandom_range(0, 63) == 0) wait_idle();
            end
            items_left -= phase_items;
            wait_idle();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d pixels under %0d register settings in %0d cycles.",
                 pixels_sent, settings_used, cycle_count);
        $display("Checked %0d escape counts, %0d of them nonzero.", checked, nonzero);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/mbt_pkg.sv
design/mbt_channels.sv
design/mbt_mul.sv
design/mbt_core.sv
design/mandelbrot_escape_tile.sv
tb/escape_count_checker.sv
tb/mandelbrot_escape_tile_tb.sv
